// File: hdl/bps_pkg.sv
package bps_pkg;

  localparam int PAL_ENTRIES   = 16;
  localparam int PAL_IW        = (PAL_ENTRIES > 2) ? $clog2(PAL_ENTRIES) : 1;
  localparam int PIX_PER_GROUP = 16;
  localparam int PIX_CW        = $clog2(PIX_PER_GROUP);
  localparam int QDEPTH        = 2;
  localparam int QAW           = (QDEPTH > 2) ? $clog2(QDEPTH) : 1;
  localparam int QCW           = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_4P   = 2'd0,
    MODE_2P   = 2'd1,
    MODE_MONO = 2'd2,
    MODE_OFF  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] p0;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [3:0]  index;
    logic [15:0] value;
  } entry_t;

  typedef struct packed {
    logic           full;
    logic           valid;
    logic [QCW-1:0] count;
  } q_stat_t;

  function automatic logic [7:0] widen3(input logic [2:0] c);
    return {c, c, c[2:1]};
  endfunction

endpackage

// File: hdl/bps_ifs.sv
interface bps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] plane_word_0;
  logic [15:0] plane_word_1;
  logic [15:0] plane_word_2;
  logic [15:0] plane_word_3;
  logic [3:0]  palette_index;
  logic [15:0] palette_value;

  modport source (output valid, cmd, plane_word_0, plane_word_1, plane_word_2,
                  plane_word_3, palette_index, palette_value, input ready);
  modport sink (input valid, cmd, plane_word_0, plane_word_1, plane_word_2,
                plane_word_3, palette_index, palette_value, output ready);
endinterface

interface bps_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] read_data;
  logic        last_result;

  modport source (output valid, red, green, blue, read_data, last_result,
                  input ready);
  modport sink (input valid, red, green, blue, read_data, last_result,
                output ready);
endinterface

// File: hdl/bps_front.sv
module bps_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  bps_in_if.sink           in_word,
  input  bps_pkg::mode_e   mode_i,
  input  bps_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output bps_pkg::entry_t  entry_o
);

  logic            fv_q;
  bps_pkg::entry_t fe_q;
  bps_pkg::entry_t fe_d;
  logic            keep;
  logic            accept;

  assign in_word.ready = !fv_q || !q_stat_i.full;
  assign accept        = in_word.valid && in_word.ready;

  always_comb begin
    fe_d       = '0;
    fe_d.p0    = in_word.plane_word_0;
    fe_d.p1    = in_word.plane_word_1;
    fe_d.p2    = in_word.plane_word_2;
    fe_d.p3    = in_word.plane_word_3;
    fe_d.index = in_word.palette_index;
    fe_d.value = in_word.palette_value;
    keep       = 1'b0;
    unique case (bps_pkg::cmd_e'(in_word.cmd))
      bps_pkg::CMD_PIXEL: begin
        fe_d.op = bps_pkg::OP_PIXEL;
        keep    = (mode_i != bps_pkg::MODE_OFF);
      end
      bps_pkg::CMD_WRITE: begin
        fe_d.op = bps_pkg::OP_WRITE;
        keep    = 1'b1;
      end
      bps_pkg::CMD_READ: begin
        fe_d.op = bps_pkg::OP_READ;
        keep    = 1'b1;
      end
      default: begin
        fe_d.op = bps_pkg::OP_PIXEL;
        keep    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (accept) begin
      fv_q <= keep;
    end else if (!q_stat_i.full) begin
      fv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fe_q <= fe_d;
    end
  end

  assign push_o  = fv_q && !q_stat_i.full;
  assign entry_o = fe_q;

endmodule

// File: hdl/bps_fifo.sv
module bps_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bps_pkg::entry_t   entry_i,
  input  logic              pop_i,
  output bps_pkg::entry_t   head_o,
  output bps_pkg::q_stat_t  stat_o
);

  bps_pkg::entry_t              mem_q [bps_pkg::QDEPTH];
  logic [bps_pkg::QAW-1:0]      wr_q;
  logic [bps_pkg::QAW-1:0]      rd_q;
  logic [bps_pkg::QCW-1:0]      cnt_q;
  logic                         do_push;
  logic                         do_pop;

  assign do_push = push_i && (cnt_q != bps_pkg::QCW'(bps_pkg::QDEPTH));
  assign do_pop  = pop_i && (cnt_q != '0);

  function automatic logic [bps_pkg::QAW-1:0] nxt(input logic [bps_pkg::QAW-1:0] p);
    return (p == bps_pkg::QAW'(bps_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= nxt(wr_q);
      end
      if (do_pop) begin
        rd_q <= nxt(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == bps_pkg::QCW'(bps_pkg::QDEPTH));
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.count = cnt_q;

endmodule

// File: hdl/bps_back.sv
module bps_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bps_pkg::mode_e   mode_i,
  input  bps_pkg::entry_t  head_i,
  input  logic             head_valid_i,
  output logic             pop_o,
  bps_out_if.source        out_word
);

  logic [15:0]                palette_q [bps_pkg::PAL_ENTRIES];
  logic                       mono_set_q;
  logic                       mono_clear_q;
  logic                       busy_q;
  logic [bps_pkg::PIX_CW-1:0] cnt_q;
  logic [15:0]                p0_q;
  logic [15:0]                p1_q;
  logic [15:0]                p2_q;
  logic [15:0]                p3_q;
  logic                       out_valid_q;
  logic [7:0]                 red_q;
  logic [7:0]                 green_q;
  logic [7:0]                 blue_q;
  logic [15:0]                rdata_q;
  logic                       last_q;

  logic [3:0]  pix_idx;
  logic [3:0]  rd_idx;
  logic [15:0] rd_word;
  logic [7:0]  mono_lvl;
  logic [7:0]  pix_r;
  logic [7:0]  pix_g;
  logic [7:0]  pix_b;
  logic        adv;
  logic        emit;
  logic        last_pix;
  logic        free;
  logic        can_pop;
  logic        wr_ok;

  assign adv      = !out_valid_q || out_word.ready;
  assign emit     = busy_q && adv;
  assign last_pix = (cnt_q == bps_pkg::PIX_CW'(bps_pkg::PIX_PER_GROUP - 1));
  assign free     = !busy_q || (emit && last_pix);

  always_comb begin
    pix_idx = {p3_q[15], p2_q[15], p1_q[15], p0_q[15]};
    if (mode_i == bps_pkg::MODE_2P) begin
      pix_idx[3:2] = 2'b00;
    end
  end

  // one palette read port shared by pixels and read commands
  assign rd_idx  = busy_q ? pix_idx : head_i.index;
  assign rd_word = ({1'b0, rd_idx} < 5'(bps_pkg::PAL_ENTRIES)) ?
                   palette_q[rd_idx[bps_pkg::PAL_IW-1:0]] : 16'h0000;

  assign mono_lvl = p0_q[15] ? {8{mono_set_q}} : {8{mono_clear_q}};

  always_comb begin
    if (mode_i == bps_pkg::MODE_MONO) begin
      pix_r = mono_lvl;
      pix_g = mono_lvl;
      pix_b = mono_lvl;
    end else begin
      pix_r = bps_pkg::widen3(rd_word[10:8]);
      pix_g = bps_pkg::widen3(rd_word[6:4]);
      pix_b = bps_pkg::widen3(rd_word[2:0]);
    end
  end

  always_comb begin
    unique case (head_i.op)
      bps_pkg::OP_PIXEL: can_pop = free;
      bps_pkg::OP_WRITE: can_pop = free;
      bps_pkg::OP_READ:  can_pop = !busy_q && adv;
      default:           can_pop = 1'b0;
    endcase
  end

  assign pop_o = head_valid_i && can_pop;
  assign wr_ok = pop_o && (head_i.op == bps_pkg::OP_WRITE) &&
                 ({1'b0, head_i.index} < 5'(bps_pkg::PAL_ENTRIES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      mono_set_q   <= 1'b0;
      mono_clear_q <= 1'b0;
      for (int i = 0; i < bps_pkg::PAL_ENTRIES; i++) begin
        palette_q[i] <= 16'h0000;
      end
    end else begin
      if (emit) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_pix) begin
          busy_q <= 1'b0;
        end
      end
      if (pop_o && (head_i.op == bps_pkg::OP_PIXEL)) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end
      if (emit || (pop_o && (head_i.op == bps_pkg::OP_READ))) begin
        out_valid_q <= 1'b1;
      end else if (adv) begin
        out_valid_q <= 1'b0;
      end
      if (wr_ok) begin
        palette_q[head_i.index[bps_pkg::PAL_IW-1:0]] <= head_i.value;
        if (head_i.index == 4'd0) begin
          mono_clear_q <= head_i.value[0];
          mono_set_q   <= !head_i.value[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && (head_i.op == bps_pkg::OP_PIXEL)) begin
      p0_q <= head_i.p0;
      p1_q <= head_i.p1;
      p2_q <= head_i.p2;
      p3_q <= head_i.p3;
    end else if (emit) begin
      p0_q <= {p0_q[14:0], 1'b0};
      p1_q <= {p1_q[14:0], 1'b0};
      p2_q <= {p2_q[14:0], 1'b0};
      p3_q <= {p3_q[14:0], 1'b0};
    end
    if (emit) begin
      red_q   <= pix_r;
      green_q <= pix_g;
      blue_q  <= pix_b;
      rdata_q <= 16'h0000;
      last_q  <= last_pix;
    end else if (pop_o && (head_i.op == bps_pkg::OP_READ)) begin
      red_q   <= 8'h00;
      green_q <= 8'h00;
      blue_q  <= 8'h00;
      rdata_q <= rd_word;
      last_q  <= 1'b1;
    end
  end

  assign out_word.valid       = out_valid_q;
  assign out_word.red         = red_q;
  assign out_word.green       = green_q;
  assign out_word.blue        = blue_q;
  assign out_word.read_data   = rdata_q;
  assign out_word.last_result = last_q;

endmodule

// File: hdl/bitplane_palette_pixel_shifter.sv
// bitplane to palette pixel shifter
// in_word_i: command words (pixel group, palette write, palette read) with
//   four plane words, palette index and palette value
// out_word_o: rgb pixels or palette read data, last_result marks the final
//   word caused by an input word
// cfg_we_i/cfg_wdata_i: display mode register, write only while idle
// a front stage registers and classifies input words, a two-word queue
//   decouples it from the back end that owns the palette and pixel shifter
// path: a palette read result passes the front stage register, the queue
//   and the output register; a group's first pixel also passes the shifter
// throughput: a pixel group gives 16 pixels, one per cycle while out_word_o
//   is ready, from the shifter and its palette read port; the next group or
//   write is taken with the last pixel, a palette read once the shifter idles
// words with no effect (unused command, pixels in mode 3) are dropped
//   in the front stage
// reset: palette entries and mono levels zero, display mode 0, queue empty
// when out_word_o is stalled the result holds, the shifter stops, the queue
//   fills and then in_word_i.ready drops
module bitplane_palette_pixel_shifter (
  input  logic        clk_i,
  input  logic        rst_ni,
  bps_in_if.sink      in_word_i,
  bps_out_if.source   out_word_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i
);

  logic             [1:0] display_mode_q;
  bps_pkg::mode_e         mode;
  bps_pkg::q_stat_t       q_stat;
  bps_pkg::entry_t        push_entry;
  bps_pkg::entry_t        head;
  logic                   push;
  logic                   pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_mode_q <= 2'd0;
    end else if (cfg_we_i) begin
      display_mode_q <= cfg_wdata_i;
    end
  end

  assign mode = bps_pkg::mode_e'(display_mode_q);

  bps_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_word  (in_word_i),
    .mode_i   (mode),
    .q_stat_i (q_stat),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  bps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  bps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode),
    .head_i       (head),
    .head_valid_i (q_stat.valid),
    .pop_o        (pop),
    .out_word     (out_word_o)
  );

  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= bps_pkg::QCW'(bps_pkg::QDEPTH))
    else $error("queue count out of range");

  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_word_o.valid && (out_word_o.read_data != 16'h0000)) |->
    (out_word_o.last_result && (out_word_o.red == 8'h00) &&
     (out_word_o.green == 8'h00) && (out_word_o.blue == 8'h00)))
    else $error("read result with pixel data");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_stat.valid)
    else $error("pop from empty queue");

endmodule

// File: verif/tb_bitplane_palette_pixel_shifter.sv
`timescale 1ns / 1ps

module tb_bitplane_palette_pixel_shifter;

  typedef struct packed {
    bps_pkg::cmd_e cmd;
    logic [15:0]   p0;
    logic [15:0]   p1;
    logic [15:0]   p2;
    logic [15:0]   p3;
    logic [3:0]    idx;
    logic [15:0]   val;
  } group_word_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] read_data;
    logic        last;
  } pixel_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;

  bps_in_if  in_word();
  bps_out_if out_word();

  bitplane_palette_pixel_shifter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  group_word_t pending_words[$];
  pixel_word_t expected_pixels[$];

  logic [15:0]    palette_shadow[16];
  logic [7:0]     mono_set_shadow;
  logic [7:0]     mono_clear_shadow;
  bps_pkg::mode_e mode_shadow;

  logic        word_taken = 1'b0;
  logic        no_idle = 1'b0;
  int          errors = 0;
  int          cycles = 0;

  initial forever #2 clk_i = ~clk_i;

  function automatic logic [7:0] expand_colour(input logic [2:0] c);
    logic [7:0] c8;
    c8 = {5'b0, c};
    return (c8 << 5) | (c8 << 2) | (c8 >> 1);
  endfunction

  function automatic logic [15:0] palette_entry(input logic [3:0] idx);
    if (int'(idx) >= bps_pkg::PAL_ENTRIES) return 16'h0;
    return palette_shadow[idx];
  endfunction

  task automatic predict_pixels(input group_word_t w);
    logic [3:0]  ci;
    logic [15:0] pw;
    logic [7:0]  lvl;
    case (w.cmd)
      bps_pkg::CMD_WRITE: begin
        if (int'(w.idx) < bps_pkg::PAL_ENTRIES) begin
          palette_shadow[w.idx] = w.val;
          if (w.idx == 4'd0) begin
            mono_clear_shadow = w.val[0] ? 8'hff : 8'h00;
            mono_set_shadow = ~mono_clear_shadow;
          end
        end
      end
      bps_pkg::CMD_READ: begin
        expected_pixels.push_back('{red: 8'h0, green: 8'h0, blue: 8'h0,
                                    read_data: palette_entry(w.idx), last: 1'b1});
      end
      bps_pkg::CMD_PIXEL: begin
        if (mode_shadow != bps_pkg::MODE_OFF) begin
          for (int j = 15; j >= 0; j--) begin
            if (mode_shadow == bps_pkg::MODE_MONO) begin
              lvl = w.p0[j] ? mono_set_shadow : mono_clear_shadow;
              expected_pixels.push_back('{red: lvl, green: lvl, blue: lvl,
                                          read_data: 16'h0, last: (j == 0)});
            end else begin
              ci = {w.p3[j], w.p2[j], w.p1[j], w.p0[j]};
              if (mode_shadow == bps_pkg::MODE_2P) ci[3:2] = 2'b00;
              pw = palette_entry(ci);
              expected_pixels.push_back('{red: expand_colour(pw[10:8]),
                                          green: expand_colour(pw[6:4]),
                                          blue: expand_colour(pw[2:0]),
                                          read_data: 16'h0, last: (j == 0)});
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic group_word_t make_word(input bps_pkg::cmd_e c,
                                            input logic [15:0] p0,
                                            input logic [15:0] p1, input logic [15:0] p2,
                                            input logic [15:0] p3, input logic [3:0] idx,
                                            input logic [15:0] val);
    return '{cmd: c, p0: p0, p1: p1, p2: p2, p3: p3, idx: idx, val: val};
  endfunction

  function automatic group_word_t random_word();
    group_word_t w;
    int          pick;
    pick = $urandom_range(0, 99);
    w.cmd = (pick < 50) ? bps_pkg::CMD_PIXEL : (pick < 75) ? bps_pkg::CMD_WRITE :
            (pick < 96) ? bps_pkg::CMD_READ : bps_pkg::CMD_NONE;
    w.p0 = 16'($urandom);
    w.p1 = 16'($urandom);
    w.p2 = 16'($urandom);
    w.p3 = 16'($urandom);
    w.idx = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
    w.val = 16'($urandom);
    return w;
  endfunction

  task automatic push_random(input int n);
    repeat (n) pending_words.push_back(random_word());
  endtask

  task automatic settle();
    while (pending_words.size() != 0 || in_word.valid) @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_mode(input bps_pkg::mode_e m);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    mode_shadow = m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // input driver
  always @(negedge clk_i) begin : drive_words
    group_word_t nx;
    logic        nv;
    if (rst_ni) begin
      out_word.ready <= no_idle || ($urandom_range(0, 99) >= 10);
      if (!in_word.valid || word_taken) begin
        nv = 1'b0;
        if (pending_words.size() != 0 && (no_idle || $urandom_range(0, 99) >= 10)) begin
          nx = pending_words.pop_front();
          nv = 1'b1;
        end
        in_word.valid <= nv;
        in_word.cmd <= nx.cmd;
        in_word.plane_word_0 <= nx.p0;
        in_word.plane_word_1 <= nx.p1;
        in_word.plane_word_2 <= nx.p2;
        in_word.plane_word_3 <= nx.p3;
        in_word.palette_index <= nx.idx;
        in_word.palette_value <= nx.val;
      end
    end
  end

  // output monitor and input capture
  always @(posedge clk_i) begin : watch_words
    pixel_word_t got;
    pixel_word_t want;
    group_word_t seen;
    word_taken = 1'b0;
    cycles++;
    if (cycles > 200000) begin
      $display("== FAIL ==");
      $finish;
    end else if (rst_ni) begin
      if (out_word.valid && out_word.ready) begin
        got = '{red: out_word.red, green: out_word.green, blue: out_word.blue,
                read_data: out_word.read_data, last: out_word.last_result};
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected word got r=%h g=%h b=%h rd=%h last=%b", $time,
                   got.red, got.green, got.blue, got.read_data, got.last);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.read_data !== want.read_data ||
              got.last !== want.last) begin
            $display("%0t: exp r=%h g=%h b=%h rd=%h l=%b got r=%h g=%h b=%h rd=%h l=%b",
                     $time, want.red, want.green, want.blue, want.read_data, want.last,
                     got.red, got.green, got.blue, got.read_data, got.last);
            errors++;
          end
        end
      end
      if (in_word.valid && in_word.ready) begin
        word_taken = 1'b1;
        seen = make_word(bps_pkg::cmd_e'(in_word.cmd), in_word.plane_word_0,
                         in_word.plane_word_1, in_word.plane_word_2, in_word.plane_word_3,
                         in_word.palette_index, in_word.palette_value);
        predict_pixels(seen);
      end
    end
  end

  initial begin
    in_word.valid = 1'b0;
    in_word.cmd = bps_pkg::CMD_PIXEL;
    in_word.plane_word_0 = 16'h0;
    in_word.plane_word_1 = 16'h0;
    in_word.plane_word_2 = 16'h0;
    in_word.plane_word_3 = 16'h0;
    in_word.palette_index = 4'h0;
    in_word.palette_value = 16'h0;
    out_word.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = bps_pkg::MODE_4P;
    for (int i = 0; i < 16; i++) palette_shadow[i] = 16'h0;
    mono_set_shadow = 8'h0;
    mono_clear_shadow = 8'h0;
    mode_shadow = bps_pkg::MODE_4P;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset contents, a pixel group and an unused command, then fill the palette
    pending_words.push_back(make_word(bps_pkg::CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0,
                                      4'd0, 16'h0));
    pending_words.push_back(make_word(bps_pkg::CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0,
                                      4'd15, 16'h0));
    pending_words.push_back(make_word(bps_pkg::CMD_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0,
                                      4'd0, 16'h0));
    pending_words.push_back(make_word(bps_pkg::CMD_NONE, 16'hffff, 16'hffff, 16'hffff,
                                      16'hffff, 4'd15, 16'hffff));
    for (int i = 0; i < 16; i++) begin
      pending_words.push_back(make_word(bps_pkg::CMD_WRITE, 16'h0, 16'h0, 16'h0, 16'h0,
                                        4'(i),
                                        (i == 0) ? 16'hffff : (i == 15) ? 16'h0000 :
                                        {4'(i), 4'(i), 4'(15 - i), 4'(i)}));
    end
    pending_words.push_back(make_word(bps_pkg::CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0,
                                      4'd0, 16'h0));
    pending_words.push_back(make_word(bps_pkg::CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0,
                                      4'd7, 16'h0));
    // index ramp 0..15 across the group
    pending_words.push_back(make_word(bps_pkg::CMD_PIXEL, 16'h5555, 16'h3333, 16'h0f0f,
                                      16'h00ff, 4'd0, 16'h0));
    pending_words.push_back(make_word(bps_pkg::CMD_PIXEL, 16'hffff, 16'hffff, 16'hffff,
                                      16'hffff, 4'd0, 16'h0));
    settle();

    set_mode(bps_pkg::MODE_2P);
    no_idle = 1'b1;
    pending_words.push_back(make_word(bps_pkg::CMD_PIXEL, 16'hf0f0, 16'hcccc, 16'hffff,
                                      16'hffff, 4'd0, 16'h0));
    push_random(15);
    settle();
    no_idle = 1'b0;

    set_mode(bps_pkg::MODE_MONO);
    pending_words.push_back(make_word(bps_pkg::CMD_WRITE, 16'h0, 16'h0, 16'h0, 16'h0,
                                      4'd0, 16'h0001));
    pending_words.push_back(make_word(bps_pkg::CMD_PIXEL, 16'ha5a5, 16'h0, 16'h0, 16'h0,
                                      4'd0, 16'h0));
    pending_words.push_back(make_word(bps_pkg::CMD_WRITE, 16'h0, 16'h0, 16'h0, 16'h0,
                                      4'd0, 16'hfffe));
    pending_words.push_back(make_word(bps_pkg::CMD_PIXEL, 16'h5a5a, 16'hffff, 16'h0, 16'h0,
                                      4'd0, 16'h0));
    push_random(15);
    settle();

    set_mode(bps_pkg::MODE_OFF);
    pending_words.push_back(make_word(bps_pkg::CMD_PIXEL, 16'hffff, 16'hffff, 16'hffff,
                                      16'hffff, 4'd0, 16'h0));
    pending_words.push_back(make_word(bps_pkg::CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0,
                                      4'd0, 16'h0));
    push_random(15);
    settle();

    set_mode(bps_pkg::MODE_4P);
    push_random(17);
    settle();
    push_random(18);
    settle();

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
